/* rtl/core/pcle_pkg.sv */
// Shared types and constants for the positional byte list engine.
// No dependencies; used by every file under rtl/core.
package pcle_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 8;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 2;
  // cell index width for the largest supported depth (256)
  localparam int IDX_MAX_W = 8;
  // taps ORed together per group register on the delete path
  localparam int TAP_GROUP = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_REAR  = 3'd3,
    CMD_INS_POS   = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_READ_FWD  = 3'd6,
    CMD_READ_REV  = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_OOB   = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT_FWD,
    CELL_ROT_REV
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_GRP,
    S_DEL_OUT,
    S_FWD,
    S_REV
  } state_e;

  // broadcast to every cell; idx is the insert/delete slot or, for a
  // forward rotation, the tail slot (count - 1)
  typedef struct packed {
    cell_op_e                op;
    logic [IDX_MAX_W-1:0]    idx;
    logic [DATA_W-1:0]       item;
  } cell_ctl_t;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   data;
    logic                data_valid;
    logic                last;
  } result_t;

endpackage

/* rtl/core/pcle_cell.sv */
// One storage cell of the list chain: holds one byte, takes a neighbor's
// byte on shifts/rotations, and captures itself into a tap on delete.
// Depends on pcle_pkg.
module pcle_cell
  import pcle_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic [DATA_W-1:0] head_i,
  output logic [DATA_W-1:0] byte_o,
  output logic [DATA_W-1:0] tap_o
);

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

  logic [DATA_W-1:0] byte_d, byte_q;
  logic [DATA_W-1:0] tap_q;

  always_comb begin
    byte_d = byte_q;
    case (ctl_i.op)
      CELL_INS: begin
        if (MY_IDX > ctl_i.idx) begin
          byte_d = left_i;
        end else if (MY_IDX == ctl_i.idx) begin
          byte_d = ctl_i.item;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctl_i.idx) begin
          byte_d = right_i;
        end
      end
      // forward: rotate within the occupied range, the tail takes the head; reverse: rotate the whole ring
      CELL_ROT_FWD: byte_d = (MY_IDX == ctl_i.idx) ? head_i : right_i;
      CELL_ROT_REV: byte_d = left_i;
      default:      byte_d = byte_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == CELL_DEL) begin
      tap_q <= (MY_IDX == ctl_i.idx) ? byte_q : '0;
    end
  end

  assign byte_o = byte_q;
  assign tap_o  = tap_q;

endmodule

/* rtl/core/pcle_ctrl.sv */
// Command sequencer: entry count, bounds checks, cell commands, read-out
// counter, delete OR-tree and the output register.
// Depends on pcle_pkg.
module pcle_ctrl
  import pcle_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [POS_W-1:0]  pos_i,
  input  logic [DATA_W-1:0] item_i,
  output cell_ctl_t         ctl_o,
  input  logic [DATA_W-1:0] head_i,
  input  logic [DATA_W-1:0] tail_i,
  input  logic [DATA_W-1:0] taps_i [DEPTH],
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_o
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IDXW = $clog2(DEPTH);
  localparam int CMPW = ((CNTW > POS_W) ? CNTW : POS_W) + 1;
  localparam int NGRP = (DEPTH + TAP_GROUP - 1) / TAP_GROUP;
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);
  localparam logic [IDXW-1:0] K_LAST   = IDXW'(DEPTH - 1);

  state_e            state_d, state_q;
  logic [CNTW-1:0]   cnt_d, cnt_q;
  logic [IDXW-1:0]   k_d, k_q;
  logic              out_valid_q;
  result_t           out_d, out_q;
  logic              out_load;
  logic              grp_en;
  logic [DATA_W-1:0] grp_or [NGRP];
  logic [DATA_W-1:0] grp_q  [NGRP];
  logic [DATA_W-1:0] del_byte;
  logic              load_ok;
  logic              in_acc;
  logic [CMPW-1:0]   pos_x, cnt_x;
  logic              full, empty;
  logic              emit;
  cell_ctl_t         ctl;

  assign load_ok    = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && load_ok;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pos_x      = CMPW'(pos_i);
  assign cnt_x      = CMPW'(cnt_q);
  assign full       = (cnt_q == CNT_FULL);
  assign empty      = (cnt_q == '0);
  // reverse read-out rotates the whole ring; bytes show at the last cell
  // only during the final count steps
  assign emit       = (CNTW'(k_q) >= (CNT_FULL - cnt_q));

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or[g] = '0;
      for (int j = 0; j < TAP_GROUP; j++) begin
        if (g * TAP_GROUP + j < DEPTH) begin
          grp_or[g] = grp_or[g] | taps_i[g * TAP_GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_en) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_q[g] <= grp_or[g];
      end
    end
  end

  always_comb begin
    del_byte = '0;
    for (int g = 0; g < NGRP; g++) begin
      del_byte = del_byte | grp_q[g];
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    out_load = 1'b0;
    grp_en   = 1'b0;
    out_d    = '{status: STAT_OK, data: '0, data_valid: 1'b0, last: 1'b1};
    ctl      = '{op: CELL_HOLD, idx: '0, item: item_i};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          case (cmd_e'(cmd_i))
            CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_POS: begin
              if (full) begin
                out_d.status = STAT_FULL;
              end else if (cmd_e'(cmd_i) == CMD_INS_POS &&
                           (pos_x == '0 || pos_x > cnt_x + CMPW'(1))) begin
                out_d.status = STAT_OOB;
              end else begin
                ctl.op = CELL_INS;
                if (cmd_e'(cmd_i) == CMD_INS_REAR) begin
                  ctl.idx = IDX_MAX_W'(cnt_q);
                end else if (cmd_e'(cmd_i) == CMD_INS_POS) begin
                  ctl.idx = IDX_MAX_W'(pos_x - CMPW'(1));
                end
                cnt_d = cnt_q + CNTW'(1);
              end
            end
            CMD_DEL_FRONT, CMD_DEL_REAR, CMD_DEL_POS: begin
              if (empty) begin
                out_d.status = STAT_EMPTY;
              end else if (cmd_e'(cmd_i) == CMD_DEL_POS &&
                           (pos_x == '0 || pos_x > cnt_x)) begin
                out_d.status = STAT_OOB;
              end else begin
                // result follows once the tap has gone through the OR-tree
                out_load = 1'b0;
                ctl.op   = CELL_DEL;
                if (cmd_e'(cmd_i) == CMD_DEL_REAR) begin
                  ctl.idx = IDX_MAX_W'(cnt_q - CNTW'(1));
                end else if (cmd_e'(cmd_i) == CMD_DEL_POS) begin
                  ctl.idx = IDX_MAX_W'(pos_x - CMPW'(1));
                end
                cnt_d   = cnt_q - CNTW'(1);
                state_d = S_DEL_GRP;
              end
            end
            default: begin
              if (empty) begin
                out_d.status = STAT_EMPTY;
              end else begin
                out_load = 1'b0;
                k_d      = '0;
                state_d  = (cmd_e'(cmd_i) == CMD_READ_FWD) ? S_FWD : S_REV;
              end
            end
          endcase
        end
      end
      S_DEL_GRP: begin
        grp_en  = 1'b1;
        state_d = S_DEL_OUT;
      end
      S_DEL_OUT: begin
        if (load_ok) begin
          out_load         = 1'b1;
          out_d.data       = del_byte;
          out_d.data_valid = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_FWD: begin
        if (load_ok) begin
          out_load         = 1'b1;
          out_d.data       = head_i;
          out_d.data_valid = 1'b1;
          out_d.last       = (CNTW'(k_q) == cnt_q - CNTW'(1));
          ctl.op           = CELL_ROT_FWD;
          ctl.idx          = IDX_MAX_W'(cnt_q - CNTW'(1));
          k_d              = k_q + IDXW'(1);
          if (out_d.last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_REV: begin
        if (!emit || load_ok) begin
          ctl.op = CELL_ROT_REV;
          k_d    = k_q + IDXW'(1);
          if (emit) begin
            out_load         = 1'b1;
            out_d.data       = tail_i;
            out_d.data_valid = 1'b1;
            out_d.last       = (k_q == K_LAST);
          end
          if (k_q == K_LAST) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign ctl_o       = ctl;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("entry count above depth");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ctl.op == CELL_INS) |=> cnt_q == $past(cnt_q) + CNTW'(1))
    else $error("insert did not bump entry count");

  a_del_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ctl.op == CELL_DEL) |=> state_q == S_DEL_GRP ##1 state_q == S_DEL_OUT)
    else $error("delete did not walk the tap tree");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FWD || state_q == S_REV) |-> cnt_q != '0)
    else $error("read-out running on empty list");

endmodule

/* rtl/core/positional_char_list_engine.sv */
// Top level of the positional byte list engine: cell chain plus sequencer.
// Depends on pcle_pkg, pcle_cell and pcle_ctrl.
//
// Holds an ordered list of up to DEPTH bytes in a chain of cells that shift
// together, so inserts at any position, and error results (full, empty, out
// of bounds), are loaded into the output register when accepted and give one
// transfer. A delete captures the removed byte in a per-cell tap and gathers
// it through a two-level registered OR tree before its transfer. A forward
// read-out rotates the occupied cells and streams one byte per cycle from
// the head while the output register can take it. A reverse read-out rotates
// the whole ring of DEPTH cells and streams from the last cell; the accepting
// cycle and the rotation steps before the final count steps load no output.
// One command is in flight at a time; the next is taken once its results are
// queued in the output register. Reset clears the state, entry count, read-out
// counter and output valid flag; cell contents need no clearing.
module positional_char_list_engine
  import pcle_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // cmd[2:0], position[10:3], item[18:11]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // status[1:0], data[9:2]
  output logic        m_axis_tuser_o,  // data_valid
  output logic        m_axis_tlast_o
);

  cell_ctl_t         ctl;
  result_t           res;
  logic [DATA_W-1:0] bytes [DEPTH];
  logic [DATA_W-1:0] taps  [DEPTH];

  pcle_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tdata_i[2:0]),
    .pos_i      (s_axis_tdata_i[10:3]),
    .item_i     (s_axis_tdata_i[18:11]),
    .ctl_o      (ctl),
    .head_i     (bytes[0]),
    .tail_i     (bytes[DEPTH-1]),
    .taps_i     (taps),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_o      (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pcle_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (bytes[(i == 0) ? DEPTH - 1 : i - 1]),
      .right_i(bytes[(i == DEPTH - 1) ? i : i + 1]),
      .head_i (bytes[0]),
      .byte_o (bytes[i]),
      .tap_o  (taps[i])
    );
  end

  assign m_axis_tdata_o = {6'b0, res.data, res.status};
  assign m_axis_tuser_o = res.data_valid;
  assign m_axis_tlast_o = res.last;

endmodule
